### hdl/i2cw_pkg.sv
package i2cw_pkg;

	localparam int unsigned ADDR_W    = 7;
	localparam int unsigned LIMIT_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_W     = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT  = 1'b1;

	localparam logic [ADDR_W-1:0]  ADDR_RESET  = 7'h3C;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd800;
	localparam logic [LIMIT_W-1:0] LIMIT_SAT   = 16'hFFFF;

	localparam logic [3:0] RECOVER_PULSES = 4'd9;
	localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_WRITE   = 2'd1;
	localparam logic [1:0] FUNC_RECOVER = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_BUS   = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       data_valid;
		logic       data_last;
		logic       scl_level;
		logic       sda_level;
	} in_t;

	typedef struct packed {
		logic       scl_pull_low;
		logic       sda_pull_low;
		logic       byte_taken;
		logic       busy_res;
		logic       done_res;
		logic [1:0] error_code;
	} out_t;

endpackage

### hdl/i2c_open_drain_write_master.sv
// the result of each tick is registered in the result queue and then shown on out_data with out_valid
// throughput: one tick transaction per cycle while in_stall is low; each tick is one bus half period
// a two-entry result queue lets ticks keep flowing while one result waits downstream
// in_stall rises only when both result entries are occupied
// arst_n clears the bus state machine to idle and the configuration registers to their reset values
module i2c_open_drain_write_master (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  i2cw_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output i2cw_pkg::out_t              out_data,
	input  logic                        cfg_we,
	input  logic [i2cw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2cw_pkg::CFG_W-1:0]  cfg_data
);
	import i2cw_pkg::*;

	// bus phases, one per half period step
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_ST_WAIT,
		PH_ST_SDA,
		PH_BIT_LOW,
		PH_BIT_HIGH,
		PH_ACK_LOW,
		PH_ACK_HIGH,
		PH_LOAD,
		PH_SP_LOW,
		PH_SP_WAIT,
		PH_SP_REL,
		PH_RC_LOW,
		PH_RC_WAIT
	} phase_t;

	// configuration registers
	logic [ADDR_W-1:0]  dev_addr_q;
	logic [LIMIT_W-1:0] limit_q;

	// bus engine state
	phase_t             phase_q, phase_d;
	logic [7:0]         shift_q, shift_d;
	logic [3:0]         bit_cnt_q, bit_cnt_d;
	logic [3:0]         pulse_cnt_q, pulse_cnt_d;
	logic [LIMIT_W-1:0] stretch_q, stretch_d;
	logic               final_q, final_d;
	logic [1:0]         err_flag_q, err_flag_d;

	// result queue: head is shown on the output, tail is the skid entry
	out_t               head_q, tail_q;
	logic [1:0]         count_q;

	out_t               res;
	logic               push, pop;

	// stretch wait helper values
	logic [LIMIT_W-1:0] stretch_inc;
	logic               scl_high;
	logic               timeout;

	assign in_stall  = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = head_q;
	assign push      = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// saturating count of low-scl half periods; timeout once it reaches the limit
	assign scl_high    = in_data.scl_level;
	assign stretch_inc = (stretch_q != LIMIT_SAT) ? stretch_q + 1'b1 : stretch_q;
	assign timeout     = !scl_high && (stretch_inc >= limit_q);

	// next state of the bus engine for this tick
	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		bit_cnt_d   = bit_cnt_q;
		pulse_cnt_d = pulse_cnt_q;
		stretch_d   = stretch_q;
		final_d     = final_q;
		err_flag_d  = err_flag_q;
		res         = '0;

		unique case (phase_q)
			PH_IDLE: begin
				if (in_data.func == FUNC_WRITE) begin
					if (!in_data.data_valid) begin
						// empty request finishes at once
						res.done_res   = 1'b1;
						res.error_code = ERR_EMPTY;
					end else begin
						err_flag_d = ERR_NONE;
						phase_d    = PH_ST_WAIT;
						stretch_d  = '0;
					end
				end else if (in_data.func == FUNC_RECOVER) begin
					err_flag_d  = ERR_NONE;
					pulse_cnt_d = '0;
					phase_d     = PH_RC_LOW;
					stretch_d   = '0;
				end
			end
			PH_ST_WAIT: begin
				if (scl_high || timeout) begin
					phase_d   = PH_ST_SDA;
					stretch_d = '0;
				end else begin
					stretch_d = stretch_inc;
				end
			end
			PH_ST_SDA: begin
				shift_d   = {dev_addr_q, 1'b0};
				final_d   = 1'b0;
				bit_cnt_d = '0;
				phase_d   = PH_BIT_LOW;
				stretch_d = '0;
			end
			PH_BIT_LOW: begin
				phase_d   = PH_BIT_HIGH;
				stretch_d = '0;
			end
			PH_BIT_HIGH: begin
				if (scl_high) begin
					shift_d   = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 1'b1;
					phase_d   = ((bit_cnt_q + 1'b1) >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_BIT_LOW;
					stretch_d = '0;
				end else if (timeout) begin
					err_flag_d = ERR_BUS;
					phase_d    = PH_SP_LOW;
					stretch_d  = '0;
				end else begin
					stretch_d = stretch_inc;
				end
			end
			PH_ACK_LOW: begin
				phase_d   = PH_ACK_HIGH;
				stretch_d = '0;
			end
			PH_ACK_HIGH: begin
				if (scl_high) begin
					if (in_data.sda_level) begin
						// nack from the target
						err_flag_d = ERR_BUS;
						phase_d    = PH_SP_LOW;
					end else if (final_q) begin
						phase_d = PH_SP_LOW;
					end else begin
						phase_d = PH_LOAD;
					end
					stretch_d = '0;
				end else if (timeout) begin
					err_flag_d = ERR_BUS;
					phase_d    = PH_SP_LOW;
					stretch_d  = '0;
				end else begin
					stretch_d = stretch_inc;
				end
			end
			PH_LOAD: begin
				// scl stays low until the next byte is offered
				if (in_data.data_valid) begin
					res.byte_taken = 1'b1;
					shift_d        = in_data.data_byte;
					final_d        = in_data.data_last;
					bit_cnt_d      = '0;
					phase_d        = PH_BIT_LOW;
					stretch_d      = '0;
				end
			end
			PH_SP_LOW: begin
				phase_d   = PH_SP_WAIT;
				stretch_d = '0;
			end
			PH_SP_WAIT: begin
				if (scl_high || timeout) begin
					phase_d   = PH_SP_REL;
					stretch_d = '0;
				end else begin
					stretch_d = stretch_inc;
				end
			end
			PH_SP_REL: begin
				res.done_res   = 1'b1;
				res.error_code = err_flag_q;
				phase_d        = PH_IDLE;
				stretch_d      = '0;
			end
			PH_RC_LOW: begin
				phase_d   = PH_RC_WAIT;
				stretch_d = '0;
			end
			PH_RC_WAIT: begin
				if (scl_high || timeout) begin
					pulse_cnt_d = pulse_cnt_q + 1'b1;
					phase_d     = ((pulse_cnt_q + 1'b1) >= RECOVER_PULSES) ? PH_SP_LOW
						: PH_RC_LOW;
					stretch_d   = '0;
				end else begin
					stretch_d = stretch_inc;
				end
			end
			default: begin
				phase_d   = PH_IDLE;
				stretch_d = '0;
			end
		endcase

		// pin drives for the coming half period follow the new phase
		unique case (phase_d)
			PH_ST_SDA: begin
				res.sda_pull_low = 1'b1;
			end
			PH_BIT_LOW: begin
				res.scl_pull_low = 1'b1;
				res.sda_pull_low = !shift_d[7];
			end
			PH_BIT_HIGH: begin
				res.sda_pull_low = !shift_d[7];
			end
			PH_ACK_LOW, PH_LOAD, PH_RC_LOW: begin
				res.scl_pull_low = 1'b1;
			end
			PH_SP_LOW: begin
				res.scl_pull_low = 1'b1;
				res.sda_pull_low = 1'b1;
			end
			PH_SP_WAIT: begin
				res.sda_pull_low = 1'b1;
			end
			default: begin
			end
		endcase

		res.busy_res = (phase_d != PH_IDLE);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= ADDR_RESET;
			limit_q    <= LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_data[ADDR_W-1:0];
				CFG_STRETCH_LIMIT:  limit_q    <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// bus engine advances once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			bit_cnt_q   <= '0;
			pulse_cnt_q <= '0;
			stretch_q   <= '0;
			final_q     <= 1'b0;
			err_flag_q  <= ERR_NONE;
		end else if (push) begin
			phase_q     <= phase_d;
			shift_q     <= shift_d;
			bit_cnt_q   <= bit_cnt_d;
			pulse_cnt_q <= pulse_cnt_d;
			stretch_q   <= stretch_d;
			final_q     <= final_d;
			err_flag_q  <= err_flag_d;
		end
	end

	// result queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// result queue payload
	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (count_q == 2'd2) begin
					head_q <= tail_q;
					tail_q <= res;
				end else begin
					head_q <= res;
				end
			end
			2'b10: begin
				if (count_q == 2'd0) begin
					head_q <= res;
				end else begin
					tail_q <= res;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			default: begin
			end
		endcase
	end

endmodule

### hdl/i2cw_checker.sv
module i2cw_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input i2cw_pkg::out_t out_data
);
	import i2cw_pkg::*;

	// a held result stays put until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// an error code only comes with the end of a transaction sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.error_code != ERR_NONE) |-> out_data.done_res)
		else $error("error code without done");

	// done leaves the engine idle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
		else $error("busy after done");

	// a loaded byte starts its first bit with scl held low
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.byte_taken |-> out_data.busy_res && out_data.scl_pull_low)
		else $error("byte taken outside a bit low phase");

	// input backpressure only when results are waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind i2c_open_drain_write_master i2cw_checker u_i2cw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import i2cw_pkg::*;

	// run guard, far above the slowest correct run
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned N_PHASES    = 8;
	localparam int unsigned PHASE_ITEMS = 120;

	// bus master states of the predictor
	typedef enum logic [4:0] {
		S_IDLE, S_START_WAIT, S_START_SDA, S_BIT_LOW, S_BIT_HIGH, S_ACK_LOW, S_ACK_HIGH,
		S_LOAD, S_STOP_LOW, S_STOP_WAIT, S_STOP_REL, S_RCV_LOW, S_RCV_WAIT
	} bus_state_t;

	// outcome of one look at scl while waiting for it to go high
	typedef enum int {W_PENDING, W_HIGH, W_TIMEOUT} scl_wait_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	i2c_open_drain_write_master u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ticks waiting to be driven, and the bus results predicted for accepted ticks
	in_t  tick_q[$];
	out_t bus_result_q[$];
	int   queued_cnt = 0;
	int   mismatch_cnt = 0;
	int   cycle_cnt = 0;

	// predictor copy of the registers and the bus master state
	logic [ADDR_W-1:0]  dev_addr = ADDR_RESET;
	logic [LIMIT_W-1:0] stretch_lim = LIMIT_RESET;
	bus_state_t         bus_state = S_IDLE;
	logic [7:0]         shift_reg = '0;
	logic [3:0]         bit_cnt = '0;
	logic [3:0]         pulse_cnt = '0;
	logic [15:0]        stretch_cnt = '0;
	logic               last_byte = 1'b0;
	logic [1:0]         err_flag = ERR_NONE;

	// every state change restarts the stretch counter
	function automatic void move_to(bus_state_t nxt);
		bus_state = nxt;
		stretch_cnt = '0;
	endfunction

	// the counter saturates, so a long stretch always ends in a timeout
	function automatic scl_wait_t scl_wait(logic scl);
		if (scl) return W_HIGH;
		if (stretch_cnt < LIMIT_SAT) stretch_cnt = stretch_cnt + 16'd1;
		if (stretch_cnt >= stretch_lim) return W_TIMEOUT;
		return W_PENDING;
	endfunction

	// one bus half period: advance the state, then the pin drives for the next half period
	function automatic out_t step_bus_master(in_t t);
		out_t      r;
		scl_wait_t w;
		r = '0;
		case (bus_state)
			S_IDLE: begin
				if (t.func == FUNC_WRITE) begin
					// a write request with no byte offered is rejected at once
					if (!t.data_valid) begin
						r.done_res = 1'b1;
						r.error_code = ERR_EMPTY;
					end else begin
						err_flag = ERR_NONE;
						move_to(S_START_WAIT);
					end
				end else if (t.func == FUNC_RECOVER) begin
					err_flag = ERR_NONE;
					pulse_cnt = '0;
					move_to(S_RCV_LOW);
				end
			end
			// a stretch timeout during start just lets the start go on
			S_START_WAIT: if (scl_wait(t.scl_level) != W_PENDING) move_to(S_START_SDA);
			S_START_SDA: begin
				shift_reg = {dev_addr, 1'b0};
				last_byte = 1'b0;
				bit_cnt = '0;
				move_to(S_BIT_LOW);
			end
			S_BIT_LOW: move_to(S_BIT_HIGH);
			S_BIT_HIGH: begin
				w = scl_wait(t.scl_level);
				if (w == W_HIGH) begin
					shift_reg = {shift_reg[6:0], 1'b0};
					bit_cnt = bit_cnt + 4'd1;
					move_to((bit_cnt >= BITS_PER_BYTE) ? S_ACK_LOW : S_BIT_LOW);
				end else if (w == W_TIMEOUT) begin
					err_flag = ERR_BUS;
					move_to(S_STOP_LOW);
				end
			end
			S_ACK_LOW: move_to(S_ACK_HIGH);
			S_ACK_HIGH: begin
				w = scl_wait(t.scl_level);
				if (w == W_HIGH) begin
					if (t.sda_level) begin
						err_flag = ERR_BUS;
						move_to(S_STOP_LOW);
					end else if (last_byte) begin
						move_to(S_STOP_LOW);
					end else begin
						move_to(S_LOAD);
					end
				end else if (w == W_TIMEOUT) begin
					err_flag = ERR_BUS;
					move_to(S_STOP_LOW);
				end
			end
			// scl is held low here until a byte is offered, with no timeout
			S_LOAD: begin
				if (t.data_valid) begin
					r.byte_taken = 1'b1;
					shift_reg = t.data_byte;
					last_byte = t.data_last;
					bit_cnt = '0;
					move_to(S_BIT_LOW);
				end
			end
			S_STOP_LOW: move_to(S_STOP_WAIT);
			S_STOP_WAIT: if (scl_wait(t.scl_level) != W_PENDING) move_to(S_STOP_REL);
			S_STOP_REL: begin
				r.done_res = 1'b1;
				r.error_code = err_flag;
				move_to(S_IDLE);
			end
			S_RCV_LOW: move_to(S_RCV_WAIT);
			S_RCV_WAIT: begin
				if (scl_wait(t.scl_level) != W_PENDING) begin
					pulse_cnt = pulse_cnt + 4'd1;
					move_to((pulse_cnt >= RECOVER_PULSES) ? S_STOP_LOW : S_RCV_LOW);
				end
			end
			default: move_to(S_IDLE);
		endcase

		case (bus_state)
			S_START_SDA: r.sda_pull_low = 1'b1;
			S_BIT_LOW: begin
				r.scl_pull_low = 1'b1;
				r.sda_pull_low = !shift_reg[7];
			end
			S_BIT_HIGH: r.sda_pull_low = !shift_reg[7];
			S_ACK_LOW, S_LOAD, S_RCV_LOW: r.scl_pull_low = 1'b1;
			S_STOP_LOW: begin
				r.scl_pull_low = 1'b1;
				r.sda_pull_low = 1'b1;
			end
			S_STOP_WAIT: r.sda_pull_low = 1'b1;
			default: ;
		endcase
		r.busy_res = (bus_state != S_IDLE);
		return r;
	endfunction

	// register writes and accepted tick transactions feed the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_DEVICE_ADDRESS) dev_addr = cfg_data[ADDR_W-1:0];
				else if (cfg_index == CFG_STRETCH_LIMIT) stretch_lim = cfg_data[LIMIT_W-1:0];
			end
			if (in_valid && !in_stall) bus_result_q.push_back(step_bus_master(in_data));
		end
	end

	// driver: bursts of random length, sometimes followed by a random gap
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0 || tick_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left != 0) gap_left <= gap_left - 1;
			end else begin
				in_valid <= 1'b1;
				in_data <= tick_q.pop_front();
				if (burst_left == 0) begin
					burst_left <= $urandom_range(0, 40);
					gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stall pattern, in one of four modes picked at random
	logic [1:0] stall_mode = 2'd0;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("** i2c_open_drain_write_master: FAILED **");
			$finish;
		end
		if (cycle_cnt % 128 == 0) stall_mode <= 2'($urandom_range(0, 3));
		case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= (cycle_cnt % 4 == 3);
			2'd2: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= (cycle_cnt % 16 < 6);
		endcase
	end

	task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatch_cnt++;
		end
	endtask

	// monitor: every accepted result against the oldest prediction
	out_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (bus_result_q.size() == 0) begin
				$display("%0t: result with nothing expected, expected none actual %p",
					$time, out_data);
				mismatch_cnt++;
			end else begin
				want = bus_result_q.pop_front();
				check_field("scl_pull_low", want.scl_pull_low, out_data.scl_pull_low);
				check_field("sda_pull_low", want.sda_pull_low, out_data.sda_pull_low);
				check_field("byte_taken", want.byte_taken, out_data.byte_taken);
				check_field("busy_res", want.busy_res, out_data.busy_res);
				check_field("done_res", want.done_res, out_data.done_res);
				check_field("error_code", want.error_code, out_data.error_code);
			end
		end
	end

	task automatic push_tick(input in_t t);
		tick_q.push_back(t);
		queued_cnt++;
	endtask

	function automatic in_t make_tick(logic [1:0] f, logic [7:0] b, logic dv, logic dl,
		logic scl, logic sda);
		in_t t;
		t.func = f;
		t.data_byte = b;
		t.data_valid = dv;
		t.data_last = dl;
		t.scl_level = scl;
		t.sda_level = sda;
		return t;
	endfunction

	// a command followed by ticks of a mostly healthy bus: short scl stretches,
	// occasional nacks, bytes sometimes held back, stray commands now and then
	task automatic gen_ticks(input logic [1:0] lead, input int n, input int nack_odds);
		in_t t;
		int  low_left;
		low_left = 0;
		push_tick(make_tick(lead, 8'($urandom), 1'b1, 1'b0, 1'b1, 1'b0));
		for (int i = 0; i < n; i++) begin
			t.func = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(1, 3)) : FUNC_TICK;
			t.data_byte = 8'($urandom);
			t.data_valid = ($urandom_range(0, 5) != 0);
			t.data_last = ($urandom_range(0, 2) == 0);
			if (low_left == 0 && $urandom_range(0, 9) == 0) low_left = $urandom_range(1, 5);
			t.scl_level = (low_left == 0);
			if (low_left != 0) low_left--;
			t.sda_level = ($urandom_range(0, nack_odds - 1) == 0);
			push_tick(t);
		end
	endtask

	// wait until every tick is driven and every result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (tick_q.size() != 0 || in_valid || bus_result_q.size() != 0) @(negedge clk);
	endtask

	// finish any transfer on a clean bus so register writes land with the master idle
	task automatic settle();
		wait_drained();
		while (bus_state != S_IDLE) begin
			push_tick(make_tick(FUNC_TICK, 8'($urandom), 1'b1, 1'b1, 1'b1, 1'b0));
			wait_drained();
		end
		repeat (3) @(negedge clk);
	endtask

	task automatic write_regs(input logic [ADDR_W-1:0] addr, input logic [LIMIT_W-1:0] lim);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_DEVICE_ADDRESS;
		cfg_data <= {{(CFG_W - ADDR_W){1'b0}}, addr};
		@(posedge clk);
		cfg_index <= CFG_STRETCH_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	logic [ADDR_W-1:0]  addr_set[N_PHASES];
	logic [LIMIT_W-1:0] lim_set[N_PHASES];
	int                 pick;
	in_t                rnd;

	initial begin
		// phase 0 runs on the reset values; zero limit times out on the first low tick
		addr_set[0] = ADDR_RESET;     lim_set[0] = LIMIT_RESET;
		addr_set[1] = '0;             lim_set[1] = '0;
		addr_set[2] = '1;             lim_set[2] = '1;
		addr_set[3] = 7'($urandom);   lim_set[3] = 16'd1;
		addr_set[4] = 7'($urandom);   lim_set[4] = 16'd2;
		addr_set[5] = 7'($urandom);   lim_set[5] = 16'd3;
		addr_set[6] = 7'($urandom);   lim_set[6] = LIMIT_RESET;
		addr_set[7] = 7'($urandom);   lim_set[7] = 16'd5;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// empty write request, unused command, a quiet tick with the byte and flags at their top and scl low
		push_tick(make_tick(FUNC_WRITE, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
		push_tick(make_tick(2'd3, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
		push_tick(make_tick(FUNC_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1));
		// recovery with a write command while busy and a clock stretch in the pulses
		push_tick(make_tick(FUNC_RECOVER, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
		for (int i = 0; i < 21; i++) begin
			push_tick(make_tick((i == 5) ? FUNC_WRITE : FUNC_TICK, 8'hA5, 1'b1, 1'b0,
				(i != 8), 1'b1));
		end
		settle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph != 0) write_regs(addr_set[ph], lim_set[ph]);
			queued_cnt = 0;
			while (queued_cnt < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					gen_ticks(FUNC_WRITE, $urandom_range(40, 140), 12);
				end else if (pick < 8) begin
					gen_ticks(FUNC_RECOVER, $urandom_range(18, 30), 2);
				end else if (pick == 8) begin
					// noise: any field value, any command
					repeat ($urandom_range(3, 10)) push_tick(in_t'($urandom));
				end else begin
					rnd = in_t'($urandom);
					rnd.func = FUNC_WRITE;
					rnd.data_valid = 1'b0;
					push_tick(rnd);
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && bus_result_q.size() == 0) begin
			$display("** i2c_open_drain_write_master: PASSED **");
		end else begin
			$display("** i2c_open_drain_write_master: FAILED **");
		end
		$finish;
	end

endmodule

### i2c_open_drain_write_master.f
hdl/i2cw_pkg.sv
hdl/i2c_open_drain_write_master.sv
hdl/i2cw_checker.sv
tb/tb_top.sv
